// ----- src/lsb_stego_extractor_top_assert.svh -----
// Assertion macros used by the extractor's top level.
`ifndef LSB_STEGO_EXTRACTOR_TOP_ASSERT_SVH
`define LSB_STEGO_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LSBX_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsbx assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LSBX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsbx assertion failed");

`endif

// ----- src/lsbx_pkg.sv -----
// Package with types, constants and codes of the LSB hidden-data extractor.
`timescale 1ns / 1ps

package lsbx_pkg;

   // Fixed decoding constants.
   localparam int LSBX_MAGIC_MAX_BYTES = 8;
   localparam int LSBX_EXT_BYTES       = 4;
   localparam int LSBX_BYTE_BITS       = 8;
   localparam int LSBX_WORD_BITS       = 32;
   localparam int LSBX_QUEUE_DEPTH     = 4;

   // Register reset values.
   localparam logic [7:0]  LSBX_HEADER_LENGTH_RST = 8'd54;
   localparam logic [3:0]  LSBX_MAGIC_LENGTH_RST  = 4'd2;
   localparam logic [63:0] LSBX_MAGIC_BYTES_RST   = 64'h0000_0000_0000_2A23;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_HEADER_LENGTH = 2'd0,
      CSR_MAGIC_LENGTH  = 2'd1,
      CSR_MAGIC_BYTES   = 2'd2
   } csr_index_type;

   // Decoding phases of one image.
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_MAGIC   = 3'd1,
      PH_EXT_LEN = 3'd2,
      PH_EXT     = 3'd3,
      PH_SEC_LEN = 3'd4,
      PH_SEC     = 3'd5,
      PH_IDLE    = 3'd6
   } phase_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_EXT_LEN  = 3'd0,
      KIND_EXT      = 3'd1,
      KIND_SEC_LEN  = 3'd2,
      KIND_SEC      = 3'd3,
      KIND_MISMATCH = 3'd4
   } kind_type;

   // One decoded result as it travels through the queue.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic        final_flag;
   } result_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- src/lsbx_if.sv -----
// Channel interfaces for the image byte input and the result output.
`timescale 1ns / 1ps

interface lsbx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] carrier_byte;
   logic       image_start;

   modport source (output valid, carrier_byte, image_start, input ready);
   modport sink (input valid, carrier_byte, image_start, output ready);
endinterface

interface lsbx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [31:0] result_value;
   logic        final_result;

   modport source (output valid, result_kind, result_value, final_result, input ready);
   modport sink (input valid, result_kind, result_value, final_result, output ready);
endinterface

// ----- src/lsbx_front.sv -----
// Front part: configuration registers, byte acceptance and bit decoding.
`timescale 1ns / 1ps

module lsbx_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_wdata,
   lsbx_req_if.sink               req_bus,
   input  lsbx_pkg::queue_status_type q_status,
   output logic                   push,
   output lsbx_pkg::result_type   push_data
);

   logic [7:0]  hlen_ff;
   logic [3:0]  mlen_ff;
   logic [63:0] magic_ff;

   lsbx_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  hc_ff, hc_in;
   logic [4:0]  bc_ff, bc_in;
   logic [31:0] sh_ff, sh_in;
   logic [3:0]  fi_ff, fi_in;
   logic [31:0] br_ff, br_in;

   lsbx_pkg::phase_type cur_ph, wph;
   logic [7:0]  cur_hc;
   logic [4:0]  cur_bc;
   logic [31:0] cur_sh;
   logic [3:0]  cur_fi, wfi, fi_p1, mcount;
   logic [31:0] cur_br, br_m1, sh_shift;
   logic [5:0]  bc_p1, need;
   logic [7:0]  magic_sel;
   logic        fire, hdr_skip, gathering, gdone, mismatch, sec_len_last;

   // The front stalls only when the queue has no room left.
   assign req_bus.ready = !q_status.full;
   assign fire = req_bus.valid && req_bus.ready;

   // Configuration registers; writes take effect at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         hlen_ff  <= lsbx_pkg::LSBX_HEADER_LENGTH_RST;
         mlen_ff  <= lsbx_pkg::LSBX_MAGIC_LENGTH_RST;
         magic_ff <= lsbx_pkg::LSBX_MAGIC_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index)
            lsbx_pkg::CSR_HEADER_LENGTH: begin
               hlen_ff <= csr_wdata[7:0];
            end
            lsbx_pkg::CSR_MAGIC_LENGTH: begin
               mlen_ff <= csr_wdata[3:0];
            end
            lsbx_pkg::CSR_MAGIC_BYTES: begin
               magic_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // A magic length above the supported maximum is clamped.
   assign mcount = (mlen_ff > 4'(lsbx_pkg::LSBX_MAGIC_MAX_BYTES)) ?
                   4'(lsbx_pkg::LSBX_MAGIC_MAX_BYTES) : mlen_ff;

   // Working values: an image start clears the decoding state first, and the
   // byte that ends the header skip already falls into the next phase.
   always_comb begin
      if (req_bus.image_start) begin
         cur_ph = lsbx_pkg::PH_HEADER;
         cur_hc = '0;
         cur_bc = '0;
         cur_sh = '0;
         cur_fi = '0;
         cur_br = '0;
      end else begin
         cur_ph = phase_ff;
         cur_hc = hc_ff;
         cur_bc = bc_ff;
         cur_sh = sh_ff;
         cur_fi = fi_ff;
         cur_br = br_ff;
      end
      hdr_skip = (cur_ph == lsbx_pkg::PH_HEADER) && (cur_hc < hlen_ff);
      if (cur_ph == lsbx_pkg::PH_HEADER) begin
         wph = (mcount != '0) ? lsbx_pkg::PH_MAGIC : lsbx_pkg::PH_EXT_LEN;
         wfi = '0;
      end else begin
         wph = cur_ph;
         wfi = cur_fi;
      end
      gathering = !hdr_skip && (wph != lsbx_pkg::PH_IDLE) &&
                  (wph != lsbx_pkg::PH_HEADER);
      need = ((wph == lsbx_pkg::PH_EXT_LEN) || (wph == lsbx_pkg::PH_SEC_LEN)) ?
             6'(lsbx_pkg::LSBX_WORD_BITS) : 6'(lsbx_pkg::LSBX_BYTE_BITS);
      sh_shift     = {cur_sh[30:0], req_bus.carrier_byte[0]};
      bc_p1        = {1'b0, cur_bc} + 6'd1;
      gdone        = bc_p1 >= need;
      magic_sel    = magic_ff[wfi[2:0] * 8 +: 8];
      mismatch     = sh_shift[7:0] != magic_sel;
      fi_p1        = wfi + 4'd1;
      br_m1        = cur_br - 32'd1;
      sec_len_last = (sh_shift == '0) || sh_shift[31];
   end

   // Next state of the decoder.
   always_comb begin
      phase_in = cur_ph;
      hc_in    = cur_hc;
      bc_in    = cur_bc;
      sh_in    = cur_sh;
      fi_in    = cur_fi;
      br_in    = cur_br;
      if (hdr_skip) begin
         hc_in = cur_hc + 8'd1;
      end else if (gathering) begin
         phase_in = wph;
         fi_in    = wfi;
         sh_in    = sh_shift;
         bc_in    = gdone ? 5'd0 : bc_p1[4:0];
         if (gdone) begin
            case (wph)
               lsbx_pkg::PH_MAGIC: begin
                  if (mismatch) begin
                     phase_in = lsbx_pkg::PH_IDLE;
                  end else if (fi_p1 >= mcount) begin
                     fi_in    = '0;
                     phase_in = lsbx_pkg::PH_EXT_LEN;
                  end else begin
                     fi_in = fi_p1;
                  end
               end
               lsbx_pkg::PH_EXT_LEN: begin
                  fi_in    = '0;
                  phase_in = lsbx_pkg::PH_EXT;
               end
               lsbx_pkg::PH_EXT: begin
                  if (fi_p1 >= 4'(lsbx_pkg::LSBX_EXT_BYTES)) begin
                     fi_in    = '0;
                     phase_in = lsbx_pkg::PH_SEC_LEN;
                  end else begin
                     fi_in = fi_p1;
                  end
               end
               lsbx_pkg::PH_SEC_LEN: begin
                  if (sec_len_last) begin
                     phase_in = lsbx_pkg::PH_IDLE;
                  end else begin
                     br_in    = sh_shift;
                     phase_in = lsbx_pkg::PH_SEC;
                  end
               end
               lsbx_pkg::PH_SEC: begin
                  br_in = br_m1;
                  if (br_m1 == '0) begin
                     phase_in = lsbx_pkg::PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Result produced by the accepted beat, if any.
   always_comb begin
      push                 = 1'b0;
      push_data.kind       = lsbx_pkg::KIND_EXT_LEN;
      push_data.value      = sh_shift;
      push_data.final_flag = 1'b0;
      if (fire && gathering && gdone) begin
         case (wph)
            lsbx_pkg::PH_MAGIC: begin
               push                 = mismatch;
               push_data.kind       = lsbx_pkg::KIND_MISMATCH;
               push_data.value      = '0;
               push_data.final_flag = 1'b1;
            end
            lsbx_pkg::PH_EXT_LEN: begin
               push = 1'b1;
            end
            lsbx_pkg::PH_EXT: begin
               push            = 1'b1;
               push_data.kind  = lsbx_pkg::KIND_EXT;
               push_data.value = {24'd0, sh_shift[7:0]};
            end
            lsbx_pkg::PH_SEC_LEN: begin
               push                 = 1'b1;
               push_data.kind       = lsbx_pkg::KIND_SEC_LEN;
               push_data.final_flag = sec_len_last;
            end
            lsbx_pkg::PH_SEC: begin
               push                 = 1'b1;
               push_data.kind       = lsbx_pkg::KIND_SEC;
               push_data.value      = {24'd0, sh_shift[7:0]};
               push_data.final_flag = br_m1 == '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Decoder state registers, updated on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lsbx_pkg::PH_HEADER;
         hc_ff    <= '0;
         bc_ff    <= '0;
         sh_ff    <= '0;
         fi_ff    <= '0;
         br_ff    <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         bc_ff    <= bc_in;
         sh_ff    <= sh_in;
         fi_ff    <= fi_in;
         br_ff    <= br_in;
      end
   end

endmodule

// ----- src/lsbx_queue.sv -----
// Short result queue between the decoder and the output stage.
`timescale 1ns / 1ps

module lsbx_queue #(
   parameter int DEPTH = lsbx_pkg::LSBX_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lsbx_pkg::result_type       push_data,
   input  logic                       pop,
   output lsbx_pkg::result_type       pop_data,
   output lsbx_pkg::queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lsbx_pkg::result_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign q_status.full  = cnt_ff == CNT_W'(DEPTH);
   assign q_status.empty = cnt_ff == '0;
   assign pop_data       = store_ff[rd_ff];

   // Pointer wrap and occupancy update.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- src/lsbx_back.sv -----
// Back part: output register that presents results on the result channel.
`timescale 1ns / 1ps

module lsbx_back (
   input  logic                       clock,
   input  logic                       reset,
   input  lsbx_pkg::queue_status_type q_status,
   input  lsbx_pkg::result_type       pop_data,
   output logic                       pop,
   lsbx_rsp_if.source                 rsp_bus
);

   logic                 valid_ff, valid_in;
   lsbx_pkg::result_type data_ff;

   // Take the next queued result whenever the register is free or drains.
   always_comb begin
      pop = (!valid_ff || rsp_bus.ready) && !q_status.empty;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= pop_data;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.result_kind  = data_ff.kind;
   assign rsp_bus.result_value = data_ff.value;
   assign rsp_bus.final_result = data_ff.final_flag;

endmodule

// ----- src/lsb_stego_extractor_top.sv -----
// Top level of the LSB hidden-data extractor.
`timescale 1ns / 1ps

// Extracts data hidden in bit 0 of image file bytes. One byte beat is accepted
// per clock cycle; the decoder computes each beat combinationally, so the
// sustained rate is one byte per cycle as long as the result side keeps up.
// A result that a byte completes passes first into the result queue and then
// into the output register, which drives rsp_bus. The queue
// (QUEUE_DEPTH entries) lets bytes keep flowing while a result waits to be
// taken; req_bus.ready drops only when the queue is full. Registers are written
// through csr_we/csr_index/csr_wdata and apply at once; write them while no
// bytes are in flight. Reset is synchronous and active high.

`include "lsb_stego_extractor_top_assert.svh"

module lsb_stego_extractor_top #(
   parameter int QUEUE_DEPTH = lsbx_pkg::LSBX_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   lsbx_req_if.sink    req_bus,
   lsbx_rsp_if.source  rsp_bus
);

   logic                       q_push, q_pop;
   lsbx_pkg::result_type       q_push_data, q_pop_data;
   lsbx_pkg::queue_status_type q_status;
   logic                       rsp_mismatch, rsp_mismatch_ok;

   lsbx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .q_status  (q_status),
      .push      (q_push),
      .push_data (q_push_data)
   );

   lsbx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_status  (q_status)
   );

   lsbx_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (q_pop_data),
      .pop      (q_pop),
      .rsp_bus  (rsp_bus)
   );

   // Terms for the mismatch check on the result channel.
   assign rsp_mismatch    = rsp_bus.valid && (rsp_bus.result_kind == lsbx_pkg::KIND_MISMATCH);
   assign rsp_mismatch_ok = rsp_bus.final_result && (rsp_bus.result_value == '0);

   // The queue can only fill up through a push in the cycle before.
   `LSBX_ASSERT_NOW(a_full_after_push, $rose(q_status.full), $past(q_push))

   // A magic mismatch ends the image and carries a zero value.
   `LSBX_ASSERT_NOW(a_mismatch_final, rsp_mismatch, rsp_mismatch_ok)

   // A pushed result reaches the queue, so it is not empty the next cycle.
   `LSBX_ASSERT_NEXT(a_push_lands, q_push, !q_status.empty)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the LSB hidden-data extractor.
`timescale 1ns / 1ps

module testbench;

   // Register index that maps to no register; writes to it must change nothing.
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int         RANDOM_BYTES     = 60;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   lsbx_req_if req_bus ();
   lsbx_rsp_if rsp_bus ();

   lsb_stego_extractor_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // Mirror of the configuration registers.
   logic [7:0]  cfg_header;
   logic [3:0]  cfg_magic_len;
   logic [63:0] cfg_magic;

   // Mirror of the decoder state.
   lsbx_pkg::phase_type dec_phase;
   logic [7:0]  hdr_count;
   logic [4:0]  bit_cnt;
   logic [31:0] bit_shift;
   logic [3:0]  field_idx;
   logic [31:0] bytes_left;

   lsbx_pkg::result_type pending_results[$];
   bit          carried_bits[$];
   int          failures;
   int          sent_count;
   bit          steady;

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int magic_bytes_used();
      return (cfg_magic_len > lsbx_pkg::LSBX_MAGIC_MAX_BYTES) ?
             lsbx_pkg::LSBX_MAGIC_MAX_BYTES : int'(cfg_magic_len);
   endfunction

   function automatic void restart_decoder();
      dec_phase  = lsbx_pkg::PH_HEADER;
      hdr_count  = '0;
      bit_cnt    = '0;
      bit_shift  = '0;
      field_idx  = '0;
      bytes_left = '0;
   endfunction

   // Shifts bit 0 of a carrier byte in; true once the field is complete.
   function automatic bit shift_in(input logic [7:0] carrier, input int need);
      bit_shift = {bit_shift[30:0], carrier[0]};
      if (int'(bit_cnt) + 1 >= need) begin
         bit_cnt = '0;
         return 1'b1;
      end
      bit_cnt = bit_cnt + 5'd1;
      return 1'b0;
   endfunction

   function automatic lsbx_pkg::result_type make_result(input lsbx_pkg::kind_type kind,
                                                        input logic [31:0] value,
                                                        input logic fin);
      lsbx_pkg::result_type r;
      r.kind       = kind;
      r.value      = value;
      r.final_flag = fin;
      return r;
   endfunction

   // Advances the decoder by one carrier byte; true when it yields a result.
   function automatic bit decode_carrier(input logic [7:0] carrier, input bit start,
                                         output lsbx_pkg::result_type r);
      int mcount;
      mcount = magic_bytes_used();
      r = '0;
      if (start) restart_decoder();
      if (dec_phase == lsbx_pkg::PH_HEADER) begin
         if (hdr_count < cfg_header) begin
            hdr_count = hdr_count + 8'd1;
            return 1'b0;
         end
         field_idx = '0;
         dec_phase = (mcount > 0) ? lsbx_pkg::PH_MAGIC : lsbx_pkg::PH_EXT_LEN;
      end
      case (dec_phase)
         lsbx_pkg::PH_MAGIC: begin
            if (!shift_in(carrier, lsbx_pkg::LSBX_BYTE_BITS)) return 1'b0;
            if (bit_shift[7:0] != cfg_magic[field_idx[2:0]*8 +: 8]) begin
               dec_phase = lsbx_pkg::PH_IDLE;
               r = make_result(lsbx_pkg::KIND_MISMATCH, '0, 1'b1);
               return 1'b1;
            end
            field_idx = field_idx + 4'd1;
            if (field_idx >= mcount) begin
               field_idx = '0;
               dec_phase = lsbx_pkg::PH_EXT_LEN;
            end
            return 1'b0;
         end
         lsbx_pkg::PH_EXT_LEN: begin
            if (!shift_in(carrier, lsbx_pkg::LSBX_WORD_BITS)) return 1'b0;
            field_idx = '0;
            dec_phase = lsbx_pkg::PH_EXT;
            r = make_result(lsbx_pkg::KIND_EXT_LEN, bit_shift, 1'b0);
            return 1'b1;
         end
         lsbx_pkg::PH_EXT: begin
            if (!shift_in(carrier, lsbx_pkg::LSBX_BYTE_BITS)) return 1'b0;
            field_idx = field_idx + 4'd1;
            if (field_idx >= lsbx_pkg::LSBX_EXT_BYTES) begin
               field_idx = '0;
               dec_phase = lsbx_pkg::PH_SEC_LEN;
            end
            r = make_result(lsbx_pkg::KIND_EXT, {24'd0, bit_shift[7:0]}, 1'b0);
            return 1'b1;
         end
         lsbx_pkg::PH_SEC_LEN: begin
            if (!shift_in(carrier, lsbx_pkg::LSBX_WORD_BITS)) return 1'b0;
            if (bit_shift == 32'd0 || bit_shift[31]) begin
               dec_phase = lsbx_pkg::PH_IDLE;
               r = make_result(lsbx_pkg::KIND_SEC_LEN, bit_shift, 1'b1);
               return 1'b1;
            end
            bytes_left = bit_shift;
            dec_phase  = lsbx_pkg::PH_SEC;
            r = make_result(lsbx_pkg::KIND_SEC_LEN, bit_shift, 1'b0);
            return 1'b1;
         end
         lsbx_pkg::PH_SEC: begin
            if (!shift_in(carrier, lsbx_pkg::LSBX_BYTE_BITS)) return 1'b0;
            bytes_left = bytes_left - 32'd1;
            r = make_result(lsbx_pkg::KIND_SEC, {24'd0, bit_shift[7:0]},
                            bytes_left == 32'd0);
            if (bytes_left == 32'd0) dec_phase = lsbx_pkg::PH_IDLE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Result side: random backpressure and a field-by-field check of each beat.
   always @(posedge clock) begin : result_check
      lsbx_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d value %h final %b",
                     $time, rsp_bus.result_kind, rsp_bus.result_value, rsp_bus.final_result);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result_kind !== want.kind) begin
               $display("%0t: result_kind expected %0d actual %0d",
                        $time, want.kind, rsp_bus.result_kind);
               failures++;
            end
            if (rsp_bus.result_value !== want.value) begin
               $display("%0t: result_value expected %h actual %h",
                        $time, want.value, rsp_bus.result_value);
               failures++;
            end
            if (rsp_bus.final_result !== want.final_flag) begin
               $display("%0t: final_result expected %b actual %b",
                        $time, want.final_flag, rsp_bus.final_result);
               failures++;
            end
         end
      end
      rsp_bus.ready <= steady || ($urandom_range(99) >= 28);
   end

   // Sends one byte beat, with an occasional gap before it, and predicts its result.
   task automatic send_byte(input logic [7:0] carrier, input bit start);
      lsbx_pkg::result_type r;
      if (!steady && $urandom_range(99) < 26) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.carrier_byte <= carrier;
      req_bus.image_start  <= start;
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
      if (decode_carrier(carrier, start, r)) pending_results.push_back(r);
   endtask

   // Lowers valid and waits until every expected result has come out.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // One register write; the caller lowers the write enable afterward.
   task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         lsbx_pkg::CSR_HEADER_LENGTH: cfg_header    = data[7:0];
         lsbx_pkg::CSR_MAGIC_LENGTH:  cfg_magic_len = data[3:0];
         lsbx_pkg::CSR_MAGIC_BYTES:   cfg_magic     = data;
         default: ;
      endcase
   endtask

   // Writes all three registers once the block is idle; junk fills unused length bits.
   task automatic set_config(input logic [7:0] hdr, input logic [3:0] mlen,
                             input logic [63:0] magic);
      logic [63:0] junk;
      junk = rand64();
      drain();
      write_reg(lsbx_pkg::CSR_HEADER_LENGTH, {junk[63:8], hdr});
      write_reg(lsbx_pkg::CSR_MAGIC_LENGTH, {junk[63:4], mlen});
      write_reg(lsbx_pkg::CSR_MAGIC_BYTES, magic);
      csr_we <= 1'b0;
   endtask

   function automatic void add_bits(input logic [63:0] value, input int count);
      for (int i = count - 1; i >= 0; i--) carried_bits.push_back(value[i]);
   endfunction

   // Hides an image in carrier bytes under the current settings and sends it.
   // A bad_byte below the magic count corrupts that magic byte; keep_bits >= 0
   // cuts the hidden stream short; tail_bits are trailing bits after the end.
   task automatic send_image(input bit mark_start, input int bad_byte,
                             input logic [31:0] secret_len, input int keep_bits,
                             input int tail_bits);
      int          mcount;
      logic [7:0]  magic_byte;
      logic [31:0] noise;
      bit          first;
      mcount = magic_bytes_used();
      carried_bits.delete();
      for (int i = 0; i < mcount; i++) begin
         magic_byte = cfg_magic[i*8 +: 8];
         if (i == bad_byte) magic_byte ^= 8'(1 << $urandom_range(7));
         add_bits(64'(magic_byte), lsbx_pkg::LSBX_BYTE_BITS);
      end
      add_bits(64'($urandom), lsbx_pkg::LSBX_WORD_BITS);
      for (int i = 0; i < lsbx_pkg::LSBX_EXT_BYTES; i++) begin
         add_bits(64'($urandom), lsbx_pkg::LSBX_BYTE_BITS);
      end
      add_bits(64'(secret_len), lsbx_pkg::LSBX_WORD_BITS);
      if (secret_len != 32'd0 && !secret_len[31]) begin
         for (int i = 0; i < secret_len; i++) begin
            add_bits(64'($urandom), lsbx_pkg::LSBX_BYTE_BITS);
         end
      end
      add_bits(rand64(), tail_bits);
      if (keep_bits >= 0) begin
         while (carried_bits.size() > keep_bits) void'(carried_bits.pop_back());
      end
      first = mark_start;
      for (int h = 0; h < cfg_header; h++) begin
         send_byte(8'($urandom), first);
         first = 1'b0;
      end
      foreach (carried_bits[k]) begin
         noise = $urandom;
         send_byte({noise[7:1], carried_bits[k]}, first);
         first = 1'b0;
      end
   endtask

   // Bytes right after reset decode as an image without any start marker.
   task automatic test_no_start_after_reset();
      send_image(1'b0, -1, 32'd3, 48, 0);
   endtask

   // Header length at zero and at its maximum.
   task automatic test_header_extremes();
      set_config(8'd0, 4'd2, lsbx_pkg::LSBX_MAGIC_BYTES_RST);
      send_image(1'b1, -1, 32'd2, -1, 0);
      set_config(8'd255, 4'd1, 64'h5A);
      send_image(1'b1, -1, 32'd1, 40, 0);
   endtask

   // No magic, oversized magic length and mismatches.
   task automatic test_magic_lengths();
      set_config(8'd3, 4'd0, rand64());
      send_image(1'b1, -1, 32'd1, -1, 0);
      set_config(8'd1, 4'd15, rand64());
      send_image(1'b1, -1, 32'd1, -1, 0);
      send_image(1'b1, 0, 32'd1, 24, 0);
      set_config(8'd2, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF);
      send_image(1'b1, 3, 32'd1, 40, 0);
   endtask

   // Secret length of zero and with the top bit set.
   task automatic test_secret_lengths();
      logic [31:0] word;
      word = $urandom;
      set_config(8'd2, 4'd2, rand64());
      send_image(1'b1, -1, 32'd0, -1, 8);
      send_image(1'b1, -1, {1'b1, word[30:0]}, -1, 8);
   endtask

   // A new image marker in the middle of an image restarts decoding.
   task automatic test_restart_mid_image();
      set_config(8'd4, 4'd2, rand64());
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b0);
      send_image(1'b1, -1, 32'd3, 9, 0);
      send_image(1'b1, -1, 32'd3, 150, 0);
   endtask

   // A write to an index past the last register changes nothing.
   task automatic test_unused_index();
      drain();
      write_reg(CSR_UNUSED_INDEX, rand64());
      csr_we <= 1'b0;
      send_image(1'b1, -1, 32'd2, 48, 0);
   endtask

   // Back-to-back beats on both sides with no idling at all.
   task automatic test_back_to_back();
      set_config(8'd1, 4'd1, rand64());
      steady = 1'b1;
      for (int i = 0; i < 2; i++) send_image(1'b1, -1, 32'($urandom_range(1, 4)), -1, 0);
      drain();
      steady = 1'b0;
   endtask

   // Mostly well-formed images with random content and settings, some noise.
   task automatic test_random_images();
      int          base;
      int          pick;
      logic [31:0] word;
      logic [31:0] secret_len;
      base = sent_count;
      while (sent_count - base < RANDOM_BYTES) begin
         if ($urandom_range(2) == 0) begin
            set_config(($urandom_range(9) == 0) ? 8'($urandom_range(255)) :
                       8'($urandom_range(6)), 4'($urandom_range(15)), rand64());
         end
         word = $urandom;
         pick = $urandom_range(99);
         secret_len = (pick < 10) ? 32'd0 :
                      (pick < 20) ? {1'b1, word[30:0]} : 32'($urandom_range(1, 6));
         pick = $urandom_range(99);
         if (pick < 70)
            send_image(1'b1, -1, secret_len, -1, $urandom_range(12));
         else if (pick < 80)
            send_image(1'b1, $urandom_range(7), secret_len, -1, $urandom_range(12));
         else if (pick < 90)
            send_image(1'b1, -1, secret_len, $urandom_range(1, 150), 0);
         else begin
            repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(9) == 0);
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = lsbx_pkg::CSR_HEADER_LENGTH;
      csr_wdata           = '0;
      req_bus.valid        = 1'b0;
      req_bus.carrier_byte = '0;
      req_bus.image_start  = 1'b0;
      rsp_bus.ready        = 1'b0;
      steady              = 1'b0;
      failures            = 0;
      sent_count          = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Predictor starts from the reset values of the block.
      cfg_header    = lsbx_pkg::LSBX_HEADER_LENGTH_RST;
      cfg_magic_len = lsbx_pkg::LSBX_MAGIC_LENGTH_RST;
      cfg_magic     = lsbx_pkg::LSBX_MAGIC_BYTES_RST;
      restart_decoder();

      test_no_start_after_reset();
      test_header_extremes();
      test_magic_lengths();
      test_secret_lengths();
      test_restart_mid_image();
      test_unused_index();
      test_back_to_back();
      test_random_images();

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
